// File: rtl/rk4_pkg.sv
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared codes, constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none
package rk4_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_MAT   = 2'd0;
    localparam logic [1:0] CMD_STATE = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // configuration register indexes
    localparam logic REG_STEP = 1'b0;
    localparam logic REG_DIM  = 1'b1;

    localparam int DT_BITS    = 24;
    localparam int DIV_STEPS  = 3;
    localparam logic [23:0] STEP_RESET = 24'd167772;
    localparam logic [5:0]  DIM_RESET  = 6'd30;

    // commands from controller to datapath
    typedef struct packed {
        logic run_start;
        logic mac_mul;
        logic mac_acc;
        logic k_sat;
        logic k_mul;
        logic k_fin;
        logic upd;
        logic use_i;
        logic fin_ld;
        logic div_step;
        logic fin_out;
    } ctrl_t;

    // status from datapath to controller
    typedef struct packed {
        logic j_last;
        logic i_last;
        logic s_last;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: rtl/rk4_ctrl.sv
// ----------------------------------------------------------------------------
// rk4_ctrl
// Sequencer: MAC loop per row, stage update, final divide and output.
// ----------------------------------------------------------------------------
`default_nettype none
module rk4_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    cmd,
    output logic               in_ready,
    input  wire rk4_pkg::stat_t st,
    output rk4_pkg::ctrl_t     ctl
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MRD  = 4'd1;
    localparam logic [3:0] S_MMUL = 4'd2;
    localparam logic [3:0] S_MACC = 4'd3;
    localparam logic [3:0] S_KSAT = 4'd4;
    localparam logic [3:0] S_KMUL = 4'd5;
    localparam logic [3:0] S_KFIN = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_FRD  = 4'd8;
    localparam logic [3:0] S_FLD  = 4'd9;
    localparam logic [3:0] S_FDIV = 4'd10;
    localparam logic [3:0] S_FOUT = 4'd11;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && cmd == rk4_pkg::CMD_RUN)
                begin
                    ctl.run_start = 1'b1;
                    state_next    = S_MRD;
                end
            end
            S_MRD:  state_next = S_MMUL;
            S_MMUL:
            begin
                ctl.mac_mul = 1'b1;
                state_next  = S_MACC;
            end
            S_MACC:
            begin
                ctl.mac_acc = 1'b1;
                state_next  = st.j_last ? S_KSAT : S_MRD;
            end
            S_KSAT:
            begin
                ctl.k_sat  = 1'b1;
                state_next = S_KMUL;
            end
            S_KMUL:
            begin
                ctl.k_mul  = 1'b1;
                state_next = S_KFIN;
            end
            S_KFIN:
            begin
                ctl.k_fin  = 1'b1;
                ctl.use_i  = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                ctl.upd    = 1'b1;
                ctl.use_i  = 1'b1;
                state_next = (st.i_last && st.s_last) ? S_FRD : S_MRD;
            end
            S_FRD:
            begin
                ctl.use_i  = 1'b1;
                state_next = S_FLD;
            end
            S_FLD:
            begin
                ctl.use_i  = 1'b1;
                ctl.fin_ld = 1'b1;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                ctl.use_i = 1'b1;
                if (st.div_done)
                    state_next = S_FOUT;
                else
                    ctl.div_step = 1'b1;
            end
            S_FOUT:
            begin
                ctl.use_i = 1'b1;
                if (st.out_free)
                begin
                    ctl.fin_out = 1'b1;
                    state_next  = st.i_last ? S_IDLE : S_FRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: rtl/rk4_dpath.sv
// ----------------------------------------------------------------------------
// rk4_dpath
// Vector memories, single MAC, stage update, divide by six, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module rk4_dpath #(
    parameter int DIM       = 32,
    parameter int FRAC_BITS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_xfer,
    input  wire logic [1:0]         cmd,
    input  wire logic [4:0]         row,
    input  wire logic [4:0]         col,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [4:0]              index,
    output logic signed [31:0]      next_value,
    output logic                    last,
    input  wire rk4_pkg::ctrl_t     ctl,
    output rk4_pkg::stat_t          st
);

    localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int XW = (AW > 5) ? AW : 5;
    localparam logic signed [63:0] P_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] K_HALF = 64'sd1 <<< (rk4_pkg::DT_BITS - 1);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // configuration registers
    logic [23:0] step_size_reg;
    logic [5:0]  active_dim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= rk4_pkg::STEP_RESET;
            active_dim_reg <= rk4_pkg::DIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == rk4_pkg::REG_STEP)
                step_size_reg <= cfg_data;
            else
                active_dim_reg <= cfg_data[5:0];
        end
    end

    // effective dimension, clamped to 1..DIM
    logic [6:0]    ad7, n7;
    logic [AW-1:0] nm1;
    always_comb
    begin
        ad7 = {1'b0, active_dim_reg};
        if (ad7 == 7'd0)
            n7 = 7'd1;
        else if (ad7 > 7'(DIM))
            n7 = 7'(DIM);
        else
            n7 = ad7;
        nm1 = AW'(n7 - 7'd1);
    end

    // loop counters
    logic [AW-1:0] i_reg, j_reg;
    logic [1:0]    s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            s_reg <= '0;
        end
        else
        begin
            if (ctl.run_start)
            begin
                i_reg <= '0;
                j_reg <= '0;
                s_reg <= '0;
            end
            if (ctl.mac_acc)
                j_reg <= (j_reg == nm1) ? '0 : j_reg + AW'(1);
            if (ctl.upd)
            begin
                if (i_reg == nm1)
                begin
                    i_reg <= '0;
                    s_reg <= s_reg + 2'd1;
                end
                else
                    i_reg <= i_reg + AW'(1);
            end
            if (ctl.fin_out)
                i_reg <= (i_reg == nm1) ? '0 : i_reg + AW'(1);
        end
    end

    assign st.j_last = (j_reg == nm1);
    assign st.i_last = (i_reg == nm1);
    assign st.s_last = (s_reg == 2'd3);

    // input write decode
    logic [XW-1:0] row_x, col_x;
    logic          row_ok, col_ok, mat_we, in_st_we;
    logic [AW-1:0] row_a, col_a;
    always_comb
    begin
        row_x    = XW'(row);
        col_x    = XW'(col);
        row_ok   = ({2'b00, row} < 7'(DIM));
        col_ok   = ({2'b00, col} < 7'(DIM));
        row_a    = AW'(row_x);
        col_a    = AW'(col_x);
        mat_we   = in_xfer && cmd == rk4_pkg::CMD_MAT && row_ok && col_ok;
        in_st_we = in_xfer && cmd == rk4_pkg::CMD_STATE && row_ok;
    end

    // matrix memory, addressed {row, col}
    logic signed [31:0] mat_mem [2**(2*AW)];
    logic signed [31:0] mat_q;
    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[{row_a, col_a}] <= value;
        mat_q <= mat_mem[{i_reg, j_reg}];
    end

    // state memory
    logic signed [31:0] x_mem [DIM];
    logic signed [31:0] x_q, nx;
    logic [AW-1:0]      x_raddr;
    assign x_raddr = ctl.use_i ? i_reg : j_reg;
    always_ff @(posedge clk)
    begin
        if (in_st_we)
            x_mem[row_a] <= value;
        else if (ctl.fin_out)
            x_mem[i_reg] <= nx;
        x_q <= x_mem[x_raddr];
    end

    // stage argument memory, two banks
    logic signed [31:0] y_mem [2*DIM];
    logic signed [31:0] y_q, y_new;
    always_ff @(posedge clk)
    begin
        if (ctl.upd)
            y_mem[{s_reg[0], i_reg}] <= y_new;
        y_q <= y_mem[{~s_reg[0], j_reg}];
    end

    // weighted sum memory
    logic signed [35:0] sum_mem [DIM];
    logic signed [35:0] sum_q, sum_new;
    always_ff @(posedge clk)
    begin
        if (ctl.upd)
            sum_mem[i_reg] <= sum_new;
        sum_q <= sum_mem[i_reg];
    end

    // MAC and derivative scaling
    logic signed [63:0] prod_reg, acc_reg, kprod_reg;
    logic signed [31:0] accsat_reg, k_reg, y_sel;
    assign y_sel = (s_reg == 2'd0) ? x_q : y_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctl.run_start || ctl.upd)
            acc_reg <= '0;
        else if (ctl.mac_acc)
            acc_reg <= acc_reg + ((prod_reg + P_HALF) >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac_mul)
            prod_reg <= 64'(y_sel) * 64'(mat_q);
        if (ctl.k_sat)
            accsat_reg <= sat32(acc_reg);
        if (ctl.k_mul)
            kprod_reg <= 64'(accsat_reg) * $signed({40'd0, step_size_reg});
        if (ctl.k_fin)
            k_reg <= sat32((kprod_reg + K_HALF) >>> rk4_pkg::DT_BITS);
    end

    // stage update
    logic signed [35:0] kw;
    logic signed [63:0] hv;
    always_comb
    begin
        kw      = (s_reg == 2'd1 || s_reg == 2'd2) ? (36'(k_reg) <<< 1) : 36'(k_reg);
        sum_new = (s_reg == 2'd0) ? kw : sum_q + kw;
        hv      = (s_reg[1] == 1'b0) ? ((64'(k_reg) + 64'sd1) >>> 1) : 64'(k_reg);
        y_new   = sat32(64'(x_q) + hv);
    end

    // divide by six: reciprocal estimate, remainder, small correction
    localparam logic [31:0] RECIP6 = 32'hAAAA_AAAA;  // floor(2^33 / 3)
    logic [34:0]        dq_reg;   // dividend, then quotient
    logic [63:0]        rp_reg;
    logic [32:0]        qe_reg;
    logic [5:0]         rem_reg;
    logic [5:0]         cnt_reg;
    logic               neg_reg;
    logic signed [31:0] xf_reg;
    logic [35:0]        mag;
    logic [32:0]        qe;
    logic [34:0]        qe6;
    logic [2:0]         corr;
    assign mag = sum_q[35] ? 36'(-sum_q) : 36'(sum_q);
    // estimate is low by at most three
    assign qe  = rp_reg[63:31];
    assign qe6 = 35'({qe, 2'b00}) + 35'({qe, 1'b0});

    always_comb
    begin
        if (rem_reg >= 6'd18)
            corr = 3'd3;
        else if (rem_reg >= 6'd12)
            corr = 3'd2;
        else if (rem_reg >= 6'd6)
            corr = 3'd1;
        else
            corr = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctl.fin_ld)
            cnt_reg <= 6'(rk4_pkg::DIV_STEPS);
        else if (ctl.div_step)
            cnt_reg <= cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin_ld)
        begin
            dq_reg  <= 35'(mag + 36'd3);
            neg_reg <= sum_q[35];
            xf_reg  <= x_q;
        end
        else if (ctl.div_step)
        begin
            if (cnt_reg == 6'd3)
                rp_reg <= 64'(dq_reg[34:3]) * 64'(RECIP6);
            else if (cnt_reg == 6'd2)
            begin
                qe_reg  <= qe;
                rem_reg <= 6'(dq_reg - qe6);
            end
            else
                dq_reg <= 35'(qe_reg) + 35'(corr);
        end
    end

    assign st.div_done = (cnt_reg == 6'd0);

    // new state element
    logic signed [63:0] qs;
    assign qs = neg_reg ? -$signed({29'd0, dq_reg}) : $signed({29'd0, dq_reg});
    assign nx = sat32(64'(xf_reg) + qs);

    // output register
    logic               out_valid_reg;
    logic [4:0]         index_reg;
    logic signed [31:0] next_value_reg;
    logic               last_reg;
    logic [XW-1:0]      i_x;
    assign i_x = XW'(i_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.fin_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin_out)
        begin
            index_reg      <= i_x[4:0];
            next_value_reg <= nx;
            last_reg       <= (i_reg == nm1);
        end
    end

    assign st.out_free = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign index       = index_reg;
    assign next_value  = next_value_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

// File: rtl/linear_rk4_step.sv
// ----------------------------------------------------------------------------
// linear_rk4_step
// One classical RK4 step of x' = J x in signed fixed point, one MAC.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets step_size
//   (index 0) and active_dim (index 1); always ready, write only when idle.
//   in channel takes matrix writes, state writes and run items. Writes are
//   accepted while the sequencer is idle. A run holds in_ready low until its
//   last element has been loaded into the output register.
//   A run with n active elements goes through the four stages row by row:
//   each multiply-accumulate reads the memories, multiplies and accumulates
//   through the single MAC, and each row is then scaled and stored; then
//   each element goes through the divide by six and output.
//   out channel gives index, next_value and last, one element per transfer,
//   held in an output register; a stalled receiver holds the sequencer
//   before the next element is written out.
//   Reset returns the registers to their defaults and the sequencer to idle;
//   matrix and state contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_rk4_step #(
    parameter int DIM       = 32,
    parameter int FRAC_BITS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         cmd,
    input  wire logic [4:0]         row,
    input  wire logic [4:0]         col,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [4:0]              index,
    output logic signed [31:0]      next_value,
    output logic                    last
);

    rk4_pkg::ctrl_t ctl;
    rk4_pkg::stat_t st;

    assign cfg_ready = 1'b1;

    rk4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    rk4_dpath #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_xfer    (in_valid && in_ready),
        .cmd        (cmd),
        .row        (row),
        .col        (col),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .index      (index),
        .next_value (next_value),
        .last       (last),
        .ctl        (ctl),
        .st         (st)
    );

endmodule
`default_nettype wire

// File: tb/linear_rk4_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_rk4_step_tb
// Self-checking bench for the RK4 step block: loads matrix and state, runs
// steps under random sender gaps and receiver stalls, and compares every
// emitted element against a fixed-point prediction held in the bench.
// ----------------------------------------------------------------------------
module linear_rk4_step_tb;

    localparam int N_MAX    = 32;
    localparam int WD_LIMIT = 8000;

    typedef struct {
        logic [4:0]  idx;
        logic [31:0] nxt;
        logic        lst;
    } elem_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [23:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = '0;
    logic [4:0] row = '0;
    logic [4:0] col = '0;
    logic signed [31:0] value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [4:0] index;
    logic signed [31:0] next_value;
    logic last;

    // bench copy of the block state
    int          jac [N_MAX*N_MAX];
    int          xvec [N_MAX];
    bit          jac_set [N_MAX*N_MAX];
    bit          x_set [N_MAX];
    logic [23:0] dt_q;
    logic [5:0]  dim_q;

    elem_t       next_state_q [$];
    int          errors = 0;
    bit          calm = 1'b0;
    int          quiet_cycles = 0;

    linear_rk4_step i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .row        (row),
        .col        (col),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .index      (index),
        .next_value (next_value),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one RK4 step on the bench state; queues the emitted elements
    function automatic void predict_rk4_step();
        int     n;
        longint stage [N_MAX];
        longint kd [N_MAX];
        longint acc_sum [N_MAX];
        longint acc;
        longint q;
        longint t;
        elem_t  e;
        n = (dim_q == 0) ? 1 : ((dim_q > N_MAX) ? N_MAX : dim_q);
        for (int i = 0; i < n; i++)
        begin
            stage[i] = xvec[i];
            acc_sum[i] = 0;
        end
        for (int s = 0; s < 4; s++)
        begin
            for (int i = 0; i < n; i++)
            begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    acc += (longint'(jac[i*N_MAX+j]) * stage[j] + (64'sd1 <<< 23)) >>> 24;
                kd[i] = sat32((sat32(acc) * longint'(dt_q) + (64'sd1 <<< 23)) >>> 24);
            end
            for (int i = 0; i < n; i++)
            begin
                acc_sum[i] += (s == 1 || s == 2) ? 2 * kd[i] : kd[i];
                if (s < 2)
                    stage[i] = sat32(longint'(xvec[i]) + ((kd[i] + 1) >>> 1));
                else
                    stage[i] = sat32(longint'(xvec[i]) + kd[i]);
            end
        end
        for (int i = 0; i < n; i++)
        begin
            t = acc_sum[i];
            q = (t >= 0) ? (t + 3) / 6 : -((-t + 3) / 6);
            xvec[i] = int'(sat32(longint'(xvec[i]) + q));
            e.idx = i[4:0];
            e.nxt = xvec[i];
            e.lst = (i == n - 1);
            next_state_q.push_back(e);
        end
    endfunction

    // send one input item, with a random gap ahead of it
    task automatic send_item(logic [1:0] c, logic [4:0] r, logic [4:0] k, logic [31:0] v);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 34 && gap < 6)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        row      <= r;
        col      <= k;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        case (c)
            rk4_pkg::CMD_MAT:
            begin
                jac[r*N_MAX+k] = v;
                jac_set[r*N_MAX+k] = 1'b1;
            end
            rk4_pkg::CMD_STATE:
            begin
                xvec[r] = v;
                x_set[r] = 1'b1;
            end
            rk4_pkg::CMD_RUN: predict_rk4_step();
            default: ;
        endcase
    endtask

    // wait for all results, then for any write still in flight
    task automatic drain();
        in_valid <= 1'b0;
        while (next_state_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic i, logic [23:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= i;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (i == rk4_pkg::REG_STEP)
            dt_q = d;
        else
            dim_q = d[5:0];
    endtask

    task automatic set_dim(int n);
        logic [23:0] d;
        d = 24'($urandom);
        d[5:0] = 6'(n);
        write_reg(rk4_pkg::REG_DIM, d);
    endtask

    function automatic logic [31:0] rand_value();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return 32'h7FFF_FFFF;
        if (sel == 1)
            return 32'h8000_0000;
        if (sel < 5)
            return $urandom;
        return $urandom_range(0, 1 << 26) - (1 << 25);
    endfunction

    // load every entry a run of size n reads that is not yet loaded
    task automatic fill_missing(int n);
        for (int i = 0; i < n; i++)
        begin
            if (!x_set[i])
                send_item(rk4_pkg::CMD_STATE, 5'(i), 5'($urandom), rand_value());
            for (int j = 0; j < n; j++)
                if (!jac_set[i*N_MAX+j])
                    send_item(rk4_pkg::CMD_MAT, 5'(i), 5'(j), rand_value());
        end
    endtask

    task automatic run_step();
        int n;
        n = (dim_q == 0) ? 1 : ((dim_q > N_MAX) ? N_MAX : dim_q);
        fill_missing(n);
        send_item(rk4_pkg::CMD_RUN, 5'($urandom), 5'($urandom), $urandom);
    endtask

    // saturation corners, largest and zero step, unused command, writes at top index
    task automatic test_directed();
        set_dim(2);
        write_reg(rk4_pkg::REG_STEP, 24'hFF_FFFF);
        send_item(rk4_pkg::CMD_MAT, 5'd0, 5'd0, 32'h7FFF_FFFF);
        send_item(rk4_pkg::CMD_MAT, 5'd0, 5'd1, 32'h8000_0000);
        send_item(rk4_pkg::CMD_MAT, 5'd1, 5'd0, 32'h0100_0000);
        send_item(rk4_pkg::CMD_MAT, 5'd1, 5'd1, 32'h0000_0000);
        send_item(rk4_pkg::CMD_STATE, 5'd0, 5'd31, 32'h7FFF_FFFF);
        send_item(rk4_pkg::CMD_STATE, 5'd1, 5'd0, 32'h8000_0000);
        run_step();
        send_item(rk4_pkg::CMD_NOP, 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_item(rk4_pkg::CMD_MAT, 5'd31, 5'd31, 32'h5555_AAAA);
        send_item(rk4_pkg::CMD_STATE, 5'd31, 5'd31, 32'hAAAA_5555);
        run_step();
        drain();
        write_reg(rk4_pkg::REG_STEP, 24'd0);
        run_step();
        drain();
        write_reg(rk4_pkg::REG_STEP, rk4_pkg::STEP_RESET);
        send_item(rk4_pkg::CMD_MAT, 5'd0, 5'd0, 32'hFF00_0000);
        send_item(rk4_pkg::CMD_MAT, 5'd1, 5'd1, 32'h0080_0000);
        send_item(rk4_pkg::CMD_STATE, 5'd0, 5'd0, 32'h0100_0000);
        run_step();
        drain();
    endtask

    // dimension zero acts as one
    task automatic test_dim_limits();
        set_dim(0);
        run_step();
        drain();
    endtask

    // random loads and runs at random small sizes and step sizes
    task automatic test_random();
        int ph;
        int cnt;
        int sel;
        int n;
        for (ph = 0; ph < 8; ph++)
        begin
            calm = (ph == 5);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            set_dim(n);
            sel = $urandom_range(0, 3);
            write_reg(rk4_pkg::REG_STEP,
                      sel == 0 ? 24'hFF_FFFF : (sel == 1 ? 24'd0 : 24'($urandom)));
            for (cnt = 0; cnt < 25; cnt++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    send_item(rk4_pkg::CMD_MAT, 5'($urandom_range(0, n - 1)),
                              5'($urandom_range(0, n - 1)), rand_value());
                else if (sel < 60)
                    send_item(rk4_pkg::CMD_STATE, 5'($urandom_range(0, n - 1)),
                              5'($urandom), rand_value());
                else if (sel < 70)
                    send_item(rk4_pkg::CMD_MAT, 5'($urandom), 5'($urandom), rand_value());
                else if (sel < 74)
                    send_item(rk4_pkg::CMD_NOP, 5'($urandom), 5'($urandom), $urandom);
                else
                    run_step();
            end
            drain();
        end
        calm = 1'b0;
    endtask

    // sender holds off until every result of the previous run has come
    task automatic test_pressure();
        set_dim(4);
        repeat (4)
        begin
            run_step();
            send_item(rk4_pkg::CMD_STATE, 5'($urandom_range(0, 3)), 5'($urandom),
                      rand_value());
            in_valid <= 1'b0;
            while (next_state_q.size() != 0)
                @(posedge clk);
            run_step();
        end
        drain();
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 34);

    // result check on every output transfer
    always @(posedge clk)
    begin
        elem_t e;
        if (out_valid && out_ready)
        begin
            if (next_state_q.size() == 0)
            begin
                $display("%0t: unexpected element index %0d value %0d", $time, index,
                         next_value);
                errors++;
            end
            else
            begin
                e = next_state_q.pop_front();
                if (index !== e.idx)
                begin
                    $display("%0t: index expected %0d actual %0d", $time, e.idx, index);
                    errors++;
                end
                if (next_value !== e.nxt)
                begin
                    $display("%0t: next_value[%0d] expected %0d actual %0d", $time, e.idx,
                             $signed(e.nxt), next_value);
                    errors++;
                end
                if (last !== e.lst)
                begin
                    $display("%0t: last[%0d] expected %0b actual %0b", $time, e.idx, e.lst,
                             last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("linear_rk4_step: mismatch");
            $finish;
        end
    end

    initial
    begin
        dt_q  = rk4_pkg::STEP_RESET;
        dim_q = rk4_pkg::DIM_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_dim_limits();
        test_random();
        test_pressure();
        drain();
        if (errors == 0 && next_state_q.size() == 0)
            $display("linear_rk4_step: match");
        else
            $display("linear_rk4_step: mismatch");
        $finish;
    end

endmodule
